[design/tieb_pkg.sv]
// Shared constants and status codes for the trigger ID event builder.
`default_nettype none

package tieb_pkg;

    localparam int MAX_LAYERS  = 8;
    localparam int QUEUE_DEPTH = 16;

    localparam int LAYER_W = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
    localparam int CNT_W   = $clog2(MAX_LAYERS + 1);
    localparam int PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int MEM_DEPTH = MAX_LAYERS * QUEUE_DEPTH;
    localparam int ADDR_W  = $clog2(MEM_DEPTH);

    localparam int TID_W   = 32;
    localparam int CFG_W   = 4;

    // Item kinds.
    localparam logic [1:0] KIND_PUSH  = 2'd0;
    localparam logic [1:0] KIND_BUILD = 2'd1;
    localparam logic [1:0] KIND_START = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd3;

    // Result status codes.
    localparam logic [2:0] ST_NOT_RUNNING = 3'd0;
    localparam logic [2:0] ST_WAITING     = 3'd1;
    localparam logic [2:0] ST_BUILT       = 3'd2;
    localparam logic [2:0] ST_DROPPED     = 3'd3;
    localparam logic [2:0] ST_STORED      = 3'd4;
    localparam logic [2:0] ST_FULL        = 3'd5;
    localparam logic [2:0] ST_CLEARED     = 3'd6;

    // Configuration register indexes.
    localparam logic CFG_RUNNING     = 1'b0;
    localparam logic CFG_LAYERS_USED = 1'b1;

    localparam logic [3:0] LAYERS_USED_RESET = 4'd8;

endpackage : tieb_pkg

`default_nettype wire

[design/trigger_id_event_builder_core.sv]
// Trigger ID event builder: per-layer queues of trigger IDs and a head-scanning sequencer.
// Push, start and refused build items give their registered result in the cycle after
// acceptance and keep busy low. A full build attempt over the used layers scans the queue
// heads twice through the single queue memory read port, with busy high while it scans.
// Results cannot be stalled by the receiver.
// Reset clears all control state, queue pointers and fill counts; the queue memory itself
// is not cleared, since an entry is read only after it has been written.
`default_nettype none

module trigger_id_event_builder_core
    import tieb_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [1:0]        kind,
    input  wire logic [2:0]        layer,
    input  wire logic [TID_W-1:0]  trigger_id,
    input  wire logic              cfg_we,
    input  wire logic              cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_data,
    output logic                   done,
    output logic [2:0]             status,
    output logic [TID_W-1:0]       trigger_id_out,
    output logic [TID_W-1:0]       event_number,
    output logic [7:0]             layer_mask
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic                  state_reg, state_next;
    logic                  running_reg;
    logic [3:0]            layers_used_reg;

    logic [FILL_W-1:0]     fill_reg [MAX_LAYERS];
    logic [FILL_W-1:0]     fill_next [MAX_LAYERS];
    logic [PTR_W-1:0]      rptr_reg [MAX_LAYERS];
    logic [PTR_W-1:0]      rptr_next [MAX_LAYERS];
    logic [PTR_W-1:0]      wptr_reg [MAX_LAYERS];
    logic [PTR_W-1:0]      wptr_next [MAX_LAYERS];
    logic [TID_W-1:0]      built_reg, built_next;

    logic                  pass_reg, pass_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  rd_vld_reg, rd_vld_next;
    logic [LAYER_W-1:0]    rd_lay_reg, rd_lay_next;
    logic [TID_W-1:0]      min_reg, min_next;
    logic [MAX_LAYERS-1:0] mask_reg, mask_next;
    logic [CNT_W-1:0]      matched_reg, matched_next;

    logic                  done_reg, done_next;
    logic [2:0]            status_reg, status_next;
    logic [TID_W-1:0]      tid_out_reg, tid_out_next;
    logic [TID_W-1:0]      evn_reg, evn_next;
    logic [MAX_LAYERS-1:0] mask_out_reg, mask_out_next;

    logic [TID_W-1:0]      id_mem [MEM_DEPTH];
    logic [TID_W-1:0]      rd_data_reg;
    logic                  mem_we;
    logic [ADDR_W-1:0]     wr_addr;
    logic [ADDR_W-1:0]     rd_addr;

    logic [CNT_W-1:0]      n_eff;
    logic                  any_empty;
    logic [LAYER_W-1:0]    push_idx;
    logic                  push_bad;
    logic [LAYER_W-1:0]    scan_idx;
    logic                  last_head;
    logic [MAX_LAYERS+7:0] mask_ext;

    // Effective number of used layers: zero counts as one, and it saturates.
    always_comb
    begin
        if (layers_used_reg == 4'd0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (32'(layers_used_reg) > MAX_LAYERS)
        begin
            n_eff = CNT_W'(MAX_LAYERS);
        end
        else
        begin
            n_eff = CNT_W'(layers_used_reg);
        end
    end

    always_comb
    begin
        any_empty = 1'b0;
        for (int i = 0; i < MAX_LAYERS; i++)
        begin
            if ((i < 32'(n_eff)) && (fill_reg[i] == '0))
            begin
                any_empty = 1'b1;
            end
        end
    end

    assign push_idx  = LAYER_W'(layer);
    assign push_bad  = (32'(layer) >= MAX_LAYERS)
                       || (32'(fill_reg[push_idx]) >= QUEUE_DEPTH);
    assign scan_idx  = cnt_reg[LAYER_W-1:0];
    assign last_head = (CNT_W'(rd_lay_reg) == (n_eff - CNT_W'(1)));

    assign wr_addr = ADDR_W'(ADDR_W'(push_idx) * ADDR_W'(QUEUE_DEPTH)
                             + ADDR_W'(wptr_reg[push_idx]));
    assign rd_addr = ADDR_W'(ADDR_W'(scan_idx) * ADDR_W'(QUEUE_DEPTH)
                             + ADDR_W'(rptr_reg[scan_idx]));

    always_comb
    begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        rptr_next     = rptr_reg;
        wptr_next     = wptr_reg;
        built_next    = built_reg;
        pass_next     = pass_reg;
        cnt_next      = cnt_reg;
        rd_vld_next   = 1'b0;
        rd_lay_next   = rd_lay_reg;
        min_next      = min_reg;
        mask_next     = mask_reg;
        matched_next  = matched_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        tid_out_next  = tid_out_reg;
        evn_next      = evn_reg;
        mask_out_next = mask_out_reg;
        mem_we        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    tid_out_next  = '0;
                    evn_next      = '0;
                    mask_out_next = '0;
                    unique case (kind)
                        KIND_PUSH:
                        begin
                            done_next = 1'b1;
                            if (push_bad)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_we = 1'b1;
                                wptr_next[push_idx] =
                                    (32'(wptr_reg[push_idx]) == QUEUE_DEPTH - 1) ? '0
                                    : wptr_reg[push_idx] + PTR_W'(1);
                                fill_next[push_idx] = fill_reg[push_idx] + FILL_W'(1);
                                status_next = ST_STORED;
                            end
                        end
                        KIND_BUILD:
                        begin
                            if (!running_reg)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_NOT_RUNNING;
                            end
                            else if (any_empty)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_WAITING;
                            end
                            else
                            begin
                                state_next   = S_SCAN;
                                pass_next    = 1'b0;
                                cnt_next     = '0;
                                min_next     = '1;
                                mask_next    = '0;
                                matched_next = '0;
                            end
                        end
                        KIND_START:
                        begin
                            done_next   = 1'b1;
                            built_next  = '0;
                            status_next = ST_CLEARED;
                        end
                        KIND_NONE:
                        begin
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // Reads are issued one layer ahead of the compare on the returned head.
                if (cnt_reg < n_eff)
                begin
                    rd_vld_next = 1'b1;
                    rd_lay_next = scan_idx;
                    cnt_next    = cnt_reg + CNT_W'(1);
                end
                if (rd_vld_reg)
                begin
                    if (!pass_reg)
                    begin
                        if (rd_data_reg < min_reg)
                        begin
                            min_next = rd_data_reg;
                        end
                        if (last_head)
                        begin
                            pass_next = 1'b1;
                            cnt_next  = '0;
                        end
                    end
                    else
                    begin
                        if (rd_data_reg == min_reg)
                        begin
                            rptr_next[rd_lay_reg] =
                                (32'(rptr_reg[rd_lay_reg]) == QUEUE_DEPTH - 1) ? '0
                                : rptr_reg[rd_lay_reg] + PTR_W'(1);
                            fill_next[rd_lay_reg] = fill_reg[rd_lay_reg] - FILL_W'(1);
                            mask_next[rd_lay_reg] = 1'b1;
                            matched_next = matched_reg + CNT_W'(1);
                        end
                        if (last_head)
                        begin
                            state_next    = S_IDLE;
                            done_next     = 1'b1;
                            tid_out_next  = min_reg;
                            mask_out_next = mask_next;
                            if (matched_next == n_eff)
                            begin
                                status_next = ST_BUILT;
                                evn_next    = built_reg;
                                built_next  = built_reg + TID_W'(1);
                            end
                            else
                            begin
                                status_next = ST_DROPPED;
                                evn_next    = '0;
                            end
                        end
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            running_reg     <= 1'b0;
            layers_used_reg <= LAYERS_USED_RESET;
            for (int i = 0; i < MAX_LAYERS; i++)
            begin
                fill_reg[i] <= '0;
                rptr_reg[i] <= '0;
                wptr_reg[i] <= '0;
            end
            built_reg   <= '0;
            pass_reg    <= 1'b0;
            cnt_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            rptr_reg   <= rptr_next;
            wptr_reg   <= wptr_next;
            built_reg  <= built_next;
            pass_reg   <= pass_next;
            cnt_reg    <= cnt_next;
            rd_vld_reg <= rd_vld_next;
            done_reg   <= done_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_RUNNING:     running_reg     <= cfg_data[0];
                    CFG_LAYERS_USED: layers_used_reg <= cfg_data[3:0];
                endcase
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        rd_lay_reg   <= rd_lay_next;
        min_reg      <= min_next;
        mask_reg     <= mask_next;
        matched_reg  <= matched_next;
        status_reg   <= status_next;
        tid_out_reg  <= tid_out_next;
        evn_reg      <= evn_next;
        mask_out_reg <= mask_out_next;
    end

    // Queue memory: one write port for pushes, one registered read port for head scans.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            id_mem[wr_addr] <= trigger_id;
        end
        rd_data_reg <= id_mem[rd_addr];
    end

    assign mask_ext = {8'd0, mask_out_reg};

    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign status         = status_reg;
    assign trigger_id_out = tid_out_reg;
    assign event_number   = evn_reg;
    assign layer_mask     = mask_ext[7:0];

endmodule : trigger_id_event_builder_core

`default_nettype wire
